// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Both sample on clk and are
// disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// prop must hold at every clock edge
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// cond must never be true at a clock edge
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`else

`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)

`endif

`endif

// ===== rtl/tlpl_pkg.sv =====
`timescale 1ns / 1ps

package tlpl_pkg;

  // index memory geometry
  localparam int unsigned INDEX_BYTES  = 65536;
  localparam int unsigned IDX_AW       = $clog2(INDEX_BYTES);

  // index layout
  localparam int unsigned HDR_BYTES    = 8;
  localparam int unsigned FIRST_ENTRY  = 8;
  localparam int unsigned SECOND_ENTRY = 9;
  localparam int unsigned WORD_BYTES   = 4;
  localparam int unsigned NUMBER_CHARS = 11;

  // datapath widths
  localparam int unsigned PTR_W  = 34;  // 8 + first_len + bucket + entry
  localparam int unsigned I_W    = 33;  // first-index offset, may pass first_len by 7
  localparam int unsigned STEP_W = 6;

  // key7 / 1000 as (key7 * DIV1000_MUL) >> DIV1000_SH, exact for 24-bit keys
  localparam int unsigned KEY7_W      = 24;
  localparam int unsigned MUL_W       = 25;
  localparam int unsigned PROD_W      = KEY7_W + MUL_W;
  localparam int unsigned DIV1000_SH  = 34;
  localparam int unsigned KEY4_W      = PROD_W - DIV1000_SH;
  localparam logic [MUL_W-1:0] DIV1000_MUL = 25'd17179870;

  // command codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic        command;
    logic [15:0] write_address;
    logic [7:0]  write_byte;
    logic [23:0] phone_prefix;
    logic [5:0]  number_length;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [31:0] record_offset;
    logic [7:0]  record_length;
  } out_t;

  // control word fields
  typedef enum logic [1:0] {PTR_HOLD, PTR_READ, PTR_ADD4, PTR_SECOND} ptr_op_t;
  typedef enum logic [2:0] {CAP_NONE, CAP_TOTAL, CAP_FLEN, CAP_OFFSET, CAP_LEN} cap_t;
  typedef enum logic [1:0] {I_HOLD, I_CLEAR, I_ADD8} i_op_t;
  typedef enum logic [2:0] {
    COND_NEVER, COND_ALWAYS, COND_HDR_BAD, COND_FIRST_END,
    COND_NE4, COND_SECOND_END, COND_NE7
  } cond_t;
  typedef enum logic [1:0] {FIN_NONE, FIN_HIT, FIN_MISS} fin_t;

  typedef struct packed {
    ptr_op_t           ptr_op;
    cap_t              cap;
    i_op_t             i_op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
    fin_t              fin;
  } uword_t;

  // program labels
  localparam logic [STEP_W-1:0] S_START  = 6'd0;
  localparam logic [STEP_W-1:0] S_TOTAL  = 6'd4;
  localparam logic [STEP_W-1:0] S_FLEN   = 6'd8;
  localparam logic [STEP_W-1:0] S_HDR    = 6'd9;
  localparam logic [STEP_W-1:0] S_FLOOP  = 6'd10;
  localparam logic [STEP_W-1:0] S_FCMP   = 6'd15;
  localparam logic [STEP_W-1:0] S_BUCKET = 6'd20;
  localparam logic [STEP_W-1:0] S_SLOOP  = 6'd21;
  localparam logic [STEP_W-1:0] S_SCMP   = 6'd26;
  localparam logic [STEP_W-1:0] S_OFFSET = 6'd30;
  localparam logic [STEP_W-1:0] S_LEN    = 6'd31;
  localparam logic [STEP_W-1:0] S_HIT    = 6'd32;
  localparam logic [STEP_W-1:0] S_MISS   = 6'd33;
  localparam logic [STEP_W-1:0] S_FSKIP  = 6'd34;
  localparam logic [STEP_W-1:0] S_SSKIP  = 6'd35;

  // microcode ROM
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w.ptr_op = PTR_HOLD;
    w.cap    = CAP_NONE;
    w.i_op   = I_HOLD;
    w.cond   = COND_NEVER;
    w.target = S_START;
    w.fin    = FIN_NONE;
    if (step inside {[S_START:S_FLEN-6'd1], [S_FLOOP+6'd1:S_FCMP-6'd1],
                     [S_FCMP+6'd1:S_BUCKET-6'd1], [S_SLOOP+6'd1:S_OFFSET]}) begin
      w.ptr_op = PTR_READ;
    end
    case (step)
      S_TOTAL: w.cap = CAP_TOTAL;
      S_FLEN: begin
        w.cap  = CAP_FLEN;
        w.i_op = I_CLEAR;
      end
      S_HDR: begin
        w.cond   = COND_HDR_BAD;
        w.target = S_MISS;
      end
      S_FLOOP: begin
        w.cond   = COND_FIRST_END;
        w.target = S_MISS;
      end
      S_FCMP: begin
        w.cond   = COND_NE4;
        w.target = S_FSKIP;
      end
      S_BUCKET: w.ptr_op = PTR_SECOND;
      S_SLOOP: begin
        w.cond   = COND_SECOND_END;
        w.target = S_MISS;
      end
      S_SCMP: begin
        w.cond   = COND_NE7;
        w.target = S_SSKIP;
      end
      S_OFFSET: w.cap = CAP_OFFSET;
      S_LEN: begin
        w.cap    = CAP_LEN;
        w.cond   = COND_ALWAYS;
        w.target = S_HIT;
      end
      S_HIT:  w.fin = FIN_HIT;
      S_MISS: w.fin = FIN_MISS;
      S_FSKIP: begin
        w.ptr_op = PTR_ADD4;
        w.i_op   = I_ADD8;
        w.cond   = COND_ALWAYS;
        w.target = S_FLOOP;
      end
      S_SSKIP: begin
        w.ptr_op = PTR_ADD4;
        w.cond   = COND_ALWAYS;
        w.target = S_SLOOP;
      end
      default: ;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/tlpl_ram.sv =====
`timescale 1ns / 1ps

// simple dual-port RAM, registered read
module tlpl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/two_level_prefix_index_lookup.sv =====
`timescale 1ns / 1ps
// Write beat: stored at the accept edge, no result; next beat may follow at once.
// Lookup: passes over first-index and second-index entries until a hit or the end of the scan;
//   a hit, a bad header or a failed scan each end in a result strobe. No beat is taken while busy.
//   Scanning is paced by the single byte-wide read port of the index RAM.
// Results are strobed for one cycle; the receiver cannot stall. busy is low again in the strobe cycle.
// Reset (rst_n low, synchronous) idles the sequencer and drops the strobe; RAM contents persist.
`include "assert_macros.svh"

module two_level_prefix_index_lookup (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  tlpl_pkg::in_t  in_data,
  output logic           out_strobe,
  output tlpl_pkg::out_t out_data
);

  import tlpl_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } st_t;

  // sequencer
  st_t               state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  uword_t            uw;
  logic              jump;

  // datapath
  logic [PTR_W-1:0]  ptr_r, ptr_nxt;     // byte pointer into the index
  logic [I_W-1:0]    i_r, i_nxt;         // offset within the first index
  logic [31:0]       acc_r, acc_nxt;     // little-endian byte assembler
  logic [31:0]       acc_w;              // assembled word incl. the byte landing now
  logic              rd_pend_r, rd_pend_nxt;
  logic [31:0]       total_r, total_nxt;
  logic [31:0]       flen_r, flen_nxt;
  logic [31:0]       off_r, off_nxt;
  logic [7:0]        len_r, len_nxt;
  logic [KEY7_W-1:0] key7_r, key7_nxt;
  logic              len_ok_r, len_ok_nxt;
  logic [PROD_W-1:0] prod_r;
  logic [KEY4_W-1:0] key4;
  logic [PTR_W-1:0]  limit;

  // result register
  logic              out_strobe_r, out_strobe_nxt;
  out_t              out_r, out_nxt;

  // RAM
  logic              ram_we;
  logic [7:0]        rdata;

  // conditions
  logic              hdr_bad, first_end, second_end, ne4, ne7;

  assign busy = (state_r == ST_RUN);

  // Writes land straight in the RAM at accept; the read port belongs to the sequencer.
  assign ram_we = !busy && start && (in_data.command == CMD_WRITE) &&
                  (32'(in_data.write_address) < 32'(INDEX_BYTES));

  tlpl_ram #(
    .WIDTH (8),
    .DEPTH (INDEX_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_AW'(in_data.write_address)),
    .wdata (in_data.write_byte),
    .raddr (ptr_r[IDX_AW-1:0]),
    .rdata (rdata)
  );

  assign uw = ucode(step_r);

  // RAM data shows up in the cycle after its read step; shift it in at the top so
  // four consecutive reads leave a little-endian word.
  assign acc_w = rd_pend_r ? {rdata, acc_r[31:8]} : acc_r;

  // 4-digit prefix: reciprocal multiply, registered; key7_r holds for the whole lookup
  assign key4 = prod_r[PROD_W-1:DIV1000_SH];

  // second scan stops at the smaller of the index length and the memory size
  assign limit = (total_r >= 32'(INDEX_BYTES)) ? PTR_W'(INDEX_BYTES) : PTR_W'(total_r);

  assign hdr_bad    = (total_r == '0) || (flen_r == '0) || !len_ok_r;
  assign first_end  = (I_W'(flen_r) <= i_r) ||
                      ((ptr_r + PTR_W'(FIRST_ENTRY)) > PTR_W'(INDEX_BYTES));
  assign second_end = (ptr_r + PTR_W'(SECOND_ENTRY)) > limit;
  assign ne4        = (acc_w != 32'(key4));
  assign ne7        = (acc_w != 32'(key7_r));

  always_comb begin
    case (uw.cond)
      COND_ALWAYS:     jump = 1'b1;
      COND_HDR_BAD:    jump = hdr_bad;
      COND_FIRST_END:  jump = first_end;
      COND_NE4:        jump = ne4;
      COND_SECOND_END: jump = second_end;
      COND_NE7:        jump = ne7;
      default:         jump = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    ptr_nxt        = ptr_r;
    i_nxt          = i_r;
    acc_nxt        = acc_w;
    rd_pend_nxt    = 1'b0;
    total_nxt      = total_r;
    flen_nxt       = flen_r;
    off_nxt        = off_r;
    len_nxt        = len_r;
    key7_nxt       = key7_r;
    len_ok_nxt     = len_ok_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    case (state_r)
      ST_IDLE: begin
        if (start && (in_data.command == CMD_LOOKUP)) begin
          state_nxt  = ST_RUN;
          step_nxt   = S_START;
          ptr_nxt    = '0;
          key7_nxt   = in_data.phone_prefix;
          len_ok_nxt = (32'(in_data.number_length) == NUMBER_CHARS);
        end
      end
      ST_RUN: begin
        rd_pend_nxt = (uw.ptr_op == PTR_READ);
        case (uw.ptr_op)
          PTR_READ:   ptr_nxt = ptr_r + PTR_W'(1);
          PTR_ADD4:   ptr_nxt = ptr_r + PTR_W'(WORD_BYTES);
          // bucket word is in acc_w this cycle
          PTR_SECOND: ptr_nxt = PTR_W'(HDR_BYTES) + PTR_W'(flen_r) + PTR_W'(acc_w);
          default:    ;
        endcase
        case (uw.i_op)
          I_CLEAR: i_nxt = '0;
          I_ADD8:  i_nxt = i_r + I_W'(FIRST_ENTRY);
          default: ;
        endcase
        case (uw.cap)
          CAP_TOTAL:  total_nxt = acc_w;
          CAP_FLEN:   flen_nxt  = acc_w;
          CAP_OFFSET: off_nxt   = total_r + acc_w;  // wraps mod 2^32
          CAP_LEN:    len_nxt   = rdata;
          default:    ;
        endcase
        step_nxt = jump ? uw.target : step_r + 1'b1;
        case (uw.fin)
          FIN_HIT: begin
            out_strobe_nxt        = 1'b1;
            out_nxt.found         = 1'b1;
            out_nxt.record_offset = off_r;
            out_nxt.record_length = len_r;
            state_nxt             = ST_IDLE;
          end
          FIN_MISS: begin
            out_strobe_nxt        = 1'b1;
            out_nxt.found         = 1'b0;
            out_nxt.record_offset = '0;
            out_nxt.record_length = '0;
            state_nxt             = ST_IDLE;
          end
          default: ;
        endcase
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= S_START;
      rd_pend_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      rd_pend_r    <= rd_pend_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    i_r      <= i_nxt;
    acc_r    <= acc_nxt;
    total_r  <= total_nxt;
    flen_r   <= flen_nxt;
    off_r    <= off_nxt;
    len_r    <= len_nxt;
    key7_r   <= key7_nxt;
    len_ok_r <= len_ok_nxt;
    prod_r   <= PROD_W'(key7_r) * PROD_W'(DIV1000_MUL);
    out_r    <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

  `ASSERT_CLK(a_strobe_after_run, out_strobe_r |-> $past(state_r == ST_RUN), "strobe without lookup")
  `ASSERT_CLK(a_miss_is_zero, (out_strobe_r && !out_r.found) |-> (out_r.record_offset == '0 && out_r.record_length == '0), "miss result not zero")
  `ASSERT_CLK(a_hit_from_hit_step, (out_strobe_r && out_r.found) |-> $past(step_r == S_HIT), "hit not from hit step")
  `ASSERT_NEVER(a_read_in_range, busy && uw.ptr_op == PTR_READ && ptr_r >= PTR_W'(INDEX_BYTES), "index read past memory")

endmodule

// ===== tb/tb_two_level_prefix_index_lookup.sv =====
`timescale 1ns / 1ps

module tb_two_level_prefix_index_lookup;
  import tlpl_pkg::*;

  // Run bounds
  localparam int unsigned TARGET_BEATS = 950;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 150;
  localparam int unsigned STAGE_BYTES  = 128;   // staging buffer, holds the largest index image built below
  localparam int unsigned MAX_FIRST    = 4;     // most first-index entries per random image
  localparam int unsigned MAX_SECOND   = 8;     // most second-index entries per random image
  localparam int unsigned NOISE_BASE   = 1024;  // stray writes land above every image

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_data = '0;
  logic out_strobe;
  out_t out_data;

  two_level_prefix_index_lookup uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // Shadow of the index RAM. index_known marks bytes that have been written;
  // a lookup must never walk over a byte that is still unknown.
  logic [7:0] index_mem   [INDEX_BYTES];
  bit         index_known [INDEX_BYTES];

  // Lookup results still owed by the block, oldest first
  out_t expected_lookups [$];

  // Image under test for the random phases
  logic [7:0]  stage_img [STAGE_BYTES];
  logic [23:0] image_keys [$];
  logic [31:0] image_prefixes [$];
  int unsigned image_len;

  int unsigned beats_sent = 0;
  int unsigned fail_count = 0;
  bit          quiet_phase = 1'b0;
  out_t        oldest_lookup;

  // Directed table row: the expected result is typed in only where it is obvious
  typedef struct {
    in_t  beat;
    bit   typed;
    out_t result;
  } probe_row_t;

  probe_row_t probe_rows [$];

  // ---------------------------------------------------------------------------
  // Lookup predictor
  // ---------------------------------------------------------------------------

  // Byte read from the shadow; remembers the first unknown byte touched.
  function automatic logic [7:0] peek_byte(longint unsigned addr, inout int hole);
    if (addr >= INDEX_BYTES) return 8'h00;
    if (!index_known[addr] && hole < 0) hole = int'(addr);
    return index_mem[addr];
  endfunction

  // Little-endian 32-bit word
  function automatic logic [31:0] peek_word(longint unsigned addr, inout int hole);
    logic [31:0] w;
    w = '0;
    for (int k = 0; k < 4; k++) w[8*k +: 8] = peek_byte(addr + k, hole);
    return w;
  endfunction

  // Walks the header, the 4-digit first index and the 7-digit second index the
  // way the block does. The walk runs whatever the length is, so hole reports
  // an unknown byte the hardware could touch even on a rejected length.
  function automatic out_t predict_lookup(logic [23:0] key7, logic [5:0] nchars,
                                          output int hole);
    out_t            res;
    logic [31:0]     total, first_len, key4, bucket;
    longint unsigned pos, limit, scanned;
    bit              have_bucket, hit;
    res = '0;
    hole = -1;
    bucket = '0;
    have_bucket = 1'b0;
    hit = 1'b0;
    total = peek_word(0, hole);
    first_len = peek_word(4, hole);
    key4 = {8'h00, key7} / 32'd1000;
    // zero total or zero first-index length: nothing to scan
    if (total != 0 && first_len != 0) begin
      scanned = 0;
      // entry counts while its start is inside first_len and all 8 bytes fit in RAM
      while (!have_bucket && scanned < 64'(first_len) &&
             64'(HDR_BYTES) + scanned + FIRST_ENTRY <= INDEX_BYTES) begin
        pos = 64'(HDR_BYTES) + scanned;
        if (peek_word(pos, hole) == key4) begin
          bucket = peek_word(pos + 4, hole);
          have_bucket = 1'b1;
        end
        scanned += FIRST_ENTRY;
      end
    end
    if (have_bucket) begin
      // second scan stops at the index end, clipped to the RAM
      limit = (64'(total) > INDEX_BYTES) ? 64'(INDEX_BYTES) : 64'(total);
      pos = 64'(HDR_BYTES) + 64'(first_len) + 64'(bucket);
      while (!hit && pos + SECOND_ENTRY <= limit) begin
        if (peek_word(pos, hole) == {8'h00, key7}) begin
          res.found         = 1'b1;
          res.record_offset = total + peek_word(pos + 4, hole);  // wraps mod 2^32
          res.record_length = peek_byte(pos + 8, hole);
          hit = 1'b1;
        end else begin
          pos += SECOND_ENTRY;
        end
      end
    end
    if (nchars != NUMBER_CHARS) res = '0;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Beat builders; the fields a command ignores carry random values
  // ---------------------------------------------------------------------------

  function automatic in_t make_write(logic [15:0] addr, logic [7:0] data);
    in_t b;
    b.command       = CMD_WRITE;
    b.write_address = addr;
    b.write_byte    = data;
    b.phone_prefix  = 24'($urandom);
    b.number_length = 6'($urandom);
    return b;
  endfunction

  function automatic in_t make_lookup(logic [23:0] key7, logic [5:0] nchars);
    in_t b;
    b.command       = CMD_LOOKUP;
    b.write_address = 16'($urandom);
    b.write_byte    = 8'($urandom);
    b.phone_prefix  = key7;
    b.number_length = nchars;
    return b;
  endfunction

  function automatic out_t hit_result(logic [31:0] offset, logic [7:0] length);
    out_t r;
    r.found         = 1'b1;
    r.record_offset = offset;
    r.record_length = length;
    return r;
  endfunction

  function automatic probe_row_t lookup_row(logic [23:0] key7, logic [5:0] nchars,
                                            bit typed, out_t result);
    probe_row_t r;
    r.beat   = make_lookup(key7, nchars);
    r.typed  = typed;
    r.result = result;
    return r;
  endfunction

  function automatic probe_row_t write_row(logic [15:0] addr, logic [7:0] data);
    probe_row_t r;
    r.beat   = make_write(addr, data);
    r.typed  = 1'b0;
    r.result = '0;
    return r;
  endfunction

  function automatic void put_word(int unsigned at, logic [31:0] w);
    for (int k = 0; k < 4; k++) stage_img[at + k] = w[8*k +: 8];
  endfunction

  // Mostly short gaps, now and then a long one; none in a quiet phase
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet_phase || roll < 45) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Holds start until the block takes the beat, then updates the shadow or
  // queues the expected lookup result. busy is sampled before the edge updates.
  task automatic issue_beat(in_t beat, bit typed, out_t typed_result);
    int unsigned gap;
    int          hole;
    out_t        res;
    start   <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    beats_sent++;
    if (beat.command == CMD_WRITE) begin
      index_mem[beat.write_address]   = beat.write_byte;
      index_known[beat.write_address] = 1'b1;
    end else begin
      res = predict_lookup(beat.phone_prefix, beat.number_length, hole);
      expected_lookups.push_back(typed ? typed_result : res);
    end
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Any byte the walk would touch that was never written gets a random value
  // first; the walk is redone since the new byte may change the path.
  task automatic send_lookup(in_t beat, bit typed, out_t typed_result);
    int   hole;
    out_t scratch;
    scratch = predict_lookup(beat.phone_prefix, beat.number_length, hole);
    while (hole >= 0) begin
      issue_beat(make_write(hole[15:0], 8'($urandom)), 1'b0, '0);
      scratch = predict_lookup(beat.phone_prefix, beat.number_length, hole);
    end
    issue_beat(beat, typed, typed_result);
  endtask

  task automatic write_stage(int unsigned len);
    for (int unsigned k = 0; k < len; k++)
      issue_beat(make_write(16'(k), stage_img[k]), 1'b0, '0);
  endtask

  // Pressure point: sender holds off until every owed result is back.
  // At least one edge passes so start is not driven twice in one step.
  task automatic drain_lookups();
    start <= 1'b0;
    @(posedge clk);
    while (expected_lookups.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Index images
  // ---------------------------------------------------------------------------

  // Fixed image for the directed table. total = 51, first_len = 16.
  //   first index : 1380 -> bucket 0, 9999 -> bucket 18
  //   second index: 1380013 {0x100, 0x20}, 1380099 {0x200, 0xff},
  //                 9999999 {0xffffffff, 0x01}
  task automatic load_directed_image();
    put_word(0, 32'd51);
    put_word(4, 32'd16);
    put_word(8, 32'd1380);
    put_word(12, 32'd0);
    put_word(16, 32'd9999);
    put_word(20, 32'd18);
    put_word(24, 32'd1380013);
    put_word(28, 32'h0000_0100);
    stage_img[32] = 8'h20;
    put_word(33, 32'd1380099);
    put_word(37, 32'h0000_0200);
    stage_img[41] = 8'hff;
    put_word(42, 32'd9999999);
    put_word(46, 32'hffff_ffff);
    stage_img[50] = 8'h01;
    write_stage(51);
  endtask

  // Random well-formed image: first-index prefixes pointing at runs of
  // second-index keys, with the odd short first_len, truncated or overlong
  // total, and buckets that point nowhere.
  task automatic load_random_image();
    int unsigned n_first, n_second, first_len, second_base, total, grp, second_end;
    logic [31:0] prefixes [MAX_FIRST];
    int          first_of [MAX_FIRST];
    logic [31:0] key7, bucket;
    for (int unsigned k = 0; k < STAGE_BYTES; k++) stage_img[k] = 8'($urandom);
    image_keys.delete();
    image_prefixes.delete();
    n_first  = $urandom_range(1, MAX_FIRST);
    n_second = $urandom_range(1, MAX_SECOND);
    for (int unsigned g = 0; g < n_first; g++) begin
      // now and then a prefix beyond four digits, for keys above 9999999
      prefixes[g] = ($urandom_range(0, 7) == 0) ? $urandom_range(10000, 16777)
                                                : $urandom_range(0, 9999);
      first_of[g] = -1;
      image_prefixes.push_back(prefixes[g]);
    end
    first_len = FIRST_ENTRY * n_first;
    // short first_len: second index overlaps the last first-index entry
    if ($urandom_range(0, 9) == 0) first_len -= $urandom_range(1, 7);
    second_base = HDR_BYTES + first_len;
    for (int unsigned j = 0; j < n_second; j++) begin
      grp = (j * n_first) / n_second;
      if (first_of[grp] < 0) first_of[grp] = j;
      key7 = prefixes[grp] * 1000 + $urandom_range(0, 999);
      if (key7 > 32'h00ff_ffff) key7 = 32'h00ff_ffff;
      image_keys.push_back(key7[23:0]);
    end
    for (int unsigned g = 0; g < n_first; g++) begin
      if (first_of[g] >= 0) bucket = SECOND_ENTRY * first_of[g];
      else if ($urandom_range(0, 1) == 0) bucket = $urandom;
      else bucket = SECOND_ENTRY * n_second;
      put_word(HDR_BYTES + FIRST_ENTRY * g, prefixes[g]);
      put_word(HDR_BYTES + FIRST_ENTRY * g + 4, bucket);
    end
    for (int unsigned j = 0; j < n_second; j++) begin
      put_word(second_base + SECOND_ENTRY * j, {8'h00, image_keys[j]});
      put_word(second_base + SECOND_ENTRY * j + 4, $urandom);
      stage_img[second_base + SECOND_ENTRY * j + 8] = 8'($urandom);
    end
    second_end = second_base + SECOND_ENTRY * n_second;
    total = second_end;
    case ($urandom_range(0, 9))
      0: total -= $urandom_range(1, SECOND_ENTRY);  // last entries cut off
      1: total += $urandom_range(1, 20);            // index runs past the image
      default: ;
    endcase
    put_word(0, total);
    put_word(4, first_len);
    image_len = (second_end > HDR_BYTES + FIRST_ENTRY * n_first) ?
                second_end : HDR_BYTES + FIRST_ENTRY * n_first;
    write_stage(image_len);
  endtask

  // One random phase: mostly lookups of keys that are present, the rest near
  // misses, random prefixes, bad lengths, stray writes and image patches.
  task automatic run_lookup_phase();
    int unsigned n_ops, roll;
    logic [31:0] key;
    quiet_phase = ($urandom_range(0, 3) == 0);
    load_random_image();
    n_ops = $urandom_range(20, 50);
    for (int unsigned op = 0; op < n_ops; op++) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        key = image_keys[$urandom_range(0, image_keys.size() - 1)];
        send_lookup(make_lookup(key[23:0], 6'(NUMBER_CHARS)), 1'b0, '0);
      end else if (roll < 67) begin
        // right prefix, most likely a missing key
        key = image_prefixes[$urandom_range(0, image_prefixes.size() - 1)] * 1000
              + $urandom_range(0, 999);
        if (key > 32'h00ff_ffff) key = 32'h00ff_ffff;
        send_lookup(make_lookup(key[23:0], 6'(NUMBER_CHARS)), 1'b0, '0);
      end else if (roll < 77) begin
        send_lookup(make_lookup(24'($urandom), 6'(NUMBER_CHARS)), 1'b0, '0);
      end else if (roll < 85) begin
        key = image_keys[$urandom_range(0, image_keys.size() - 1)];
        send_lookup(make_lookup(key[23:0], 6'($urandom)), 1'b0, '0);
      end else if (roll < 93) begin
        issue_beat(make_write(16'($urandom_range(NOISE_BASE, INDEX_BYTES - 1)),
                              8'($urandom)), 1'b0, '0);
      end else begin
        // corrupt an entry byte; header is left alone
        issue_beat(make_write(16'($urandom_range(HDR_BYTES, image_len - 1)),
                              8'($urandom)), 1'b0, '0);
      end
    end
    quiet_phase = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every strobe must match the oldest owed lookup
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_lookups.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: found=%0b offset=%h length=%h",
                   out_data.found, out_data.record_offset, out_data.record_length);
      end else begin
        oldest_lookup = expected_lookups.pop_front();
        if (out_data.found !== oldest_lookup.found ||
            out_data.record_offset !== oldest_lookup.record_offset ||
            out_data.record_length !== oldest_lookup.record_length) begin
          fail_count++;
          if (fail_count <= 10)
            $display("lookup mismatch: exp found=%0b offset=%h length=%h, got found=%0b offset=%h length=%h",
                     oldest_lookup.found, oldest_lookup.record_offset,
                     oldest_lookup.record_length, out_data.found,
                     out_data.record_offset, out_data.record_length);
        end
      end
    end
  end

  // Hard stop if the block hangs
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: fixed image first, header always written before any lookup
    load_directed_image();

    // hits, including data offset wrapping past 2^32
    probe_rows.push_back(lookup_row(24'd1380013, 6'd11, 1'b1, hit_result(32'h0000_0133, 8'h20)));
    probe_rows.push_back(lookup_row(24'd1380099, 6'd11, 1'b1, hit_result(32'h0000_0233, 8'hff)));
    probe_rows.push_back(lookup_row(24'd9999999, 6'd11, 1'b1, hit_result(32'h0000_0032, 8'h01)));
    // wrong length never hits
    probe_rows.push_back(lookup_row(24'd1380013, 6'd10, 1'b1, '0));
    probe_rows.push_back(lookup_row(24'd1380013, 6'd63, 1'b1, '0));
    probe_rows.push_back(lookup_row(24'd1380013, 6'd0, 1'b1, '0));
    // prefix found, key absent: scan runs to the index end
    probe_rows.push_back(lookup_row(24'd1380050, 6'd11, 1'b1, '0));
    probe_rows.push_back(lookup_row(24'd9999000, 6'd11, 1'b1, '0));
    // no first-index match; zero prefix; prefix above the 7-digit range
    probe_rows.push_back(lookup_row(24'd1234567, 6'd11, 1'b1, '0));
    probe_rows.push_back(lookup_row(24'd0, 6'd11, 1'b1, '0));
    probe_rows.push_back(lookup_row(24'hff_ffff, 6'd11, 1'b1, '0));
    // zero total index length
    probe_rows.push_back(write_row(16'd0, 8'h00));
    probe_rows.push_back(lookup_row(24'd1380013, 6'd11, 1'b1, '0));
    probe_rows.push_back(write_row(16'd0, 8'h33));
    // zero first-index length
    probe_rows.push_back(write_row(16'd4, 8'h00));
    probe_rows.push_back(lookup_row(24'd1380013, 6'd11, 1'b1, '0));
    probe_rows.push_back(write_row(16'd4, 8'h10));
    // total near 2^32: scan clipped to RAM, offset sum wraps
    probe_rows.push_back(write_row(16'd3, 8'hff));
    probe_rows.push_back(lookup_row(24'd1380013, 6'd11, 1'b1, hit_result(32'hff00_0133, 8'h20)));
    probe_rows.push_back(lookup_row(24'd9999999, 6'd11, 1'b1, hit_result(32'hff00_0032, 8'h01)));
    probe_rows.push_back(write_row(16'd3, 8'h00));
    // first_len all ones: second index starts far beyond the RAM
    probe_rows.push_back(write_row(16'd4, 8'hff));
    probe_rows.push_back(write_row(16'd5, 8'hff));
    probe_rows.push_back(write_row(16'd6, 8'hff));
    probe_rows.push_back(write_row(16'd7, 8'hff));
    probe_rows.push_back(lookup_row(24'd1380013, 6'd11, 1'b0, '0));

    foreach (probe_rows[r]) begin
      if (probe_rows[r].beat.command == CMD_LOOKUP)
        send_lookup(probe_rows[r].beat, probe_rows[r].typed, probe_rows[r].result);
      else
        issue_beat(probe_rows[r].beat, 1'b0, '0);
    end
    drain_lookups();

    // Random phases, each on a fresh image, drained at the end of each
    while (beats_sent < TARGET_BEATS) begin
      run_lookup_phase();
      drain_lookups();
    end

    start <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
